// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsv_pkg.sv =====
// ----------------------------------------------------------------------------
// lsv_pkg
// Types and constants shared by the surface labelling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsv_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_AW = 3;
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FOREGROUND = 3'd0,
    CFG_SURFACE    = 3'd1,
    CFG_WIDTH      = 3'd2,
    CFG_HEIGHT     = 3'd3,
    CFG_DEPTH      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] fg;
    logic [DATA_W-1:0] surface;
    logic [8:0]        width;
    logic [8:0]        height;
    logic [15:0]       depth;
  } cfg_t;

  typedef struct packed {
    logic xm;
    logic xp;
    logic ym;
    logic yp;
    logic zm;
    logic zp;
  } nbr_t;

  typedef struct packed {
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] xm;
    logic [DATA_W-1:0] xp;
    logic [DATA_W-1:0] ym;
    logic [DATA_W-1:0] yp;
    logic [DATA_W-1:0] zm;
    logic [DATA_W-1:0] zp;
    nbr_t              has;
    logic              last;
  } window_t;

  typedef struct packed {
    logic    valid;
    window_t win;
  } push_t;

  typedef struct packed {
    logic [QCW-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/lsv_front.sv =====
// ----------------------------------------------------------------------------
// lsv_front
// Accepts voxels, tracks input and result positions and reads the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsv_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire lsv_pkg::cfg_t          cfg,
  input  wire                         cfg_hold,
  input  wire                         restart,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire [lsv_pkg::DATA_W-1:0]   in_tdata,
  input  wire                         in_tuser,
  input  wire lsv_pkg::q_status_t     q_stat,
  output lsv_pkg::push_t              push
);

  localparam int STORE = 2 * MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam logic [AW:0] S_EXT = (AW+1)'(STORE);

  logic [lsv_pkg::DATA_W-1:0] mem0 [STORE];
  logic [lsv_pkg::DATA_W-1:0] mem1 [STORE];
  logic [lsv_pkg::DATA_W-1:0] mem2 [STORE];

  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [HW-1:0] eff_h_r, eff_h_nxt;
  logic [15:0]   eff_d_r, eff_d_nxt;
  logic [PW-1:0] plane_r;

  logic [XW-1:0] pos_x_r, pos_x_nxt, ex_r, ex_nxt;
  logic [YW-1:0] pos_y_r, pos_y_nxt, ey_r, ey_nxt;
  logic [15:0]   pos_z_r, pos_z_nxt, ez_r, ez_nxt;
  logic [AW-1:0] na_r, na_nxt, ea_r, ea_nxt;

  logic          acc, complete, is_vox, emit;
  logic          x_end, y_end, ex_end, ey_end;
  logic [AW:0]   ea_ext, w_ext, p_ext, t_yp;
  logic [AW-1:0] a_xm, a_xp, a_ym, a_yp, a_zm;
  lsv_pkg::nbr_t has;

  logic                       s1_valid_r;
  logic [lsv_pkg::DATA_W-1:0] rd_c_r, rd_xm_r, rd_xp_r, rd_ym_r, rd_yp_r, rd_zm_r;
  logic [lsv_pkg::DATA_W-1:0] inc_r;
  lsv_pkg::nbr_t              has_r;
  logic                       last_r;

  always_comb begin
    if (cfg.width == 9'd0) begin
      eff_w_nxt = WW'(1);
    end else if (16'(cfg.width) > 16'(MAX_WIDTH)) begin
      eff_w_nxt = WW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = WW'(cfg.width);
    end
    if (cfg.height == 9'd0) begin
      eff_h_nxt = HW'(1);
    end else if (16'(cfg.height) > 16'(MAX_HEIGHT)) begin
      eff_h_nxt = HW'(MAX_HEIGHT);
    end else begin
      eff_h_nxt = HW'(cfg.height);
    end
    eff_d_nxt = (cfg.depth == 16'd0) ? 16'd1 : cfg.depth;
  end

  always_ff @(posedge clk) begin
    eff_w_r <= eff_w_nxt;
    eff_h_r <= eff_h_nxt;
    eff_d_r <= eff_d_nxt;
    plane_r <= PW'(PW'(eff_w_nxt) * PW'(eff_h_nxt));
  end

  assign in_tready = !cfg_hold &&
                     ((lsv_pkg::QCW+1)'(q_stat.count) + (lsv_pkg::QCW+1)'(s1_valid_r)
                      < (lsv_pkg::QCW+1)'(lsv_pkg::QDEPTH));
  assign acc      = in_tvalid && in_tready;
  assign complete = pos_z_r >= eff_d_r;
  assign is_vox   = !in_tuser && !complete;
  assign emit     = acc && ((is_vox && pos_z_r != 16'd0) || complete);

  assign x_end  = (WW+1)'(pos_x_r) + 1'b1 == (WW+1)'(eff_w_r);
  assign y_end  = (HW+1)'(pos_y_r) + 1'b1 == (HW+1)'(eff_h_r);
  assign ex_end = (WW+1)'(ex_r) + 1'b1 == (WW+1)'(eff_w_r);
  assign ey_end = (HW+1)'(ey_r) + 1'b1 == (HW+1)'(eff_h_r);

  assign has.xm = ex_r != '0;
  assign has.xp = !ex_end;
  assign has.ym = ey_r != '0;
  assign has.yp = !ey_end;
  assign has.zm = ez_r != 16'd0;
  assign has.zp = 17'(ez_r) + 1'b1 < 17'(eff_d_r);

  assign ea_ext = {1'b0, ea_r};
  assign w_ext  = (AW+1)'(eff_w_r);
  assign p_ext  = (AW+1)'(plane_r);
  assign t_yp   = ea_ext + w_ext;
  assign a_xm   = (ea_r == '0) ? AW'(STORE - 1) : ea_r - 1'b1;
  assign a_xp   = (ea_ext + 1'b1 == S_EXT) ? '0 : ea_r + 1'b1;
  assign a_ym   = (ea_ext >= w_ext) ? AW'(ea_ext - w_ext) : AW'(ea_ext + S_EXT - w_ext);
  assign a_yp   = (t_yp >= S_EXT) ? AW'(t_yp - S_EXT) : AW'(t_yp);
  assign a_zm   = (ea_ext >= p_ext) ? AW'(ea_ext - p_ext) : AW'(ea_ext + S_EXT - p_ext);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    na_nxt    = na_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    ez_nxt    = ez_r;
    ea_nxt    = ea_r;
    if (acc && is_vox) begin
      na_nxt = (({1'b0, na_r} + 1'b1) == S_EXT) ? '0 : na_r + 1'b1;
      if (x_end) begin
        pos_x_nxt = '0;
        if (y_end) begin
          pos_y_nxt = '0;
          pos_z_nxt = pos_z_r + 16'd1;
        end else begin
          pos_y_nxt = pos_y_r + 1'b1;
        end
      end else begin
        pos_x_nxt = pos_x_r + 1'b1;
      end
    end
    if (emit) begin
      ea_nxt = (a_xp == '0) ? '0 : a_xp;
      if (ex_end) begin
        ex_nxt = '0;
        if (ey_end) begin
          ey_nxt = '0;
          ez_nxt = ez_r + 16'd1;
        end else begin
          ey_nxt = ey_r + 1'b1;
        end
      end else begin
        ex_nxt = ex_r + 1'b1;
      end
    end
    if (restart || (emit && !has.xp && !has.yp && !has.zp)) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      pos_z_nxt = 16'd0;
      na_nxt    = '0;
      ex_nxt    = '0;
      ey_nxt    = '0;
      ez_nxt    = 16'd0;
      ea_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      pos_z_r    <= 16'd0;
      na_r       <= '0;
      ex_r       <= '0;
      ey_r       <= '0;
      ez_r       <= 16'd0;
      ea_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      pos_z_r    <= pos_z_nxt;
      na_r       <= na_nxt;
      ex_r       <= ex_nxt;
      ey_r       <= ey_nxt;
      ez_r       <= ez_nxt;
      ea_r       <= ea_nxt;
      s1_valid_r <= emit;
    end
  end

  // Reads see the contents from before this cycle's write.
  always_ff @(posedge clk) begin
    if (emit) begin
      rd_c_r  <= mem0[ea_r];
      rd_xm_r <= mem0[a_xm];
      rd_xp_r <= mem1[a_xp];
      rd_ym_r <= mem1[a_ym];
      rd_yp_r <= mem2[a_yp];
      rd_zm_r <= mem2[a_zm];
      inc_r   <= in_tdata;
      has_r   <= has;
      last_r  <= !has.xp && !has.yp && !has.zp;
    end
    if (acc && is_vox) begin
      mem0[na_r] <= in_tdata;
      mem1[na_r] <= in_tdata;
      mem2[na_r] <= in_tdata;
    end
  end

  always_comb begin
    push.valid    = s1_valid_r;
    push.win.c    = rd_c_r;
    push.win.xm   = rd_xm_r;
    push.win.xp   = rd_xp_r;
    push.win.ym   = rd_ym_r;
    push.win.yp   = rd_yp_r;
    push.win.zm   = rd_zm_r;
    push.win.zp   = inc_r;
    push.win.has  = has_r;
    push.win.last = last_r;
  end

endmodule

`default_nettype wire

// ===== rtl/lsv_back.sv =====
// ----------------------------------------------------------------------------
// lsv_back
// Queues read windows, classifies the center voxel and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsv_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire lsv_pkg::cfg_t          cfg,
  input  wire lsv_pkg::push_t         push,
  output lsv_pkg::q_status_t          q_stat,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [lsv_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  lsv_pkg::window_t q_r [lsv_pkg::QDEPTH];
  logic [lsv_pkg::QPW-1:0] wp_r, rp_r;
  logic [lsv_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic                    pop;
  lsv_pkg::window_t        head;
  logic                    edge_hit;
  logic [lsv_pkg::DATA_W-1:0] res;
  logic                    ov_r;
  logic [lsv_pkg::DATA_W-1:0] od_r;
  logic                    ol_r;

  assign head = q_r[rp_r];
  assign pop  = (cnt_r != '0) && (!ov_r || out_tready);

  always_comb begin
    edge_hit = (head.has.xm && head.xm != cfg.fg) ||
               (head.has.xp && head.xp != cfg.fg) ||
               (head.has.ym && head.ym != cfg.fg) ||
               (head.has.yp && head.yp != cfg.fg) ||
               (head.has.zm && head.zm != cfg.fg) ||
               (head.has.zp && head.zp != cfg.fg);
    res = (head.c == cfg.fg && edge_hit) ? cfg.surface : '0;
    cnt_nxt = cnt_r + lsv_pkg::QCW'(push.valid) - lsv_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[wp_r] <= push.win;
    end
    if (pop) begin
      od_r <= res;
      ol_r <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      wp_r  <= wp_r + lsv_pkg::QPW'(push.valid);
      rp_r  <= rp_r + lsv_pkg::QPW'(pop);
      cnt_r <= cnt_nxt;
      if (pop) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign q_stat.count = cnt_r;
  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tlast    = ol_r;

endmodule

`default_nettype wire

// ===== rtl/label_surface_voxels.sv =====
// ----------------------------------------------------------------------------
// label_surface_voxels
// Face-connected surface labelling of a raster voxel stream.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on both channels while out_tready stays high.
// Result path: the result for voxel e passes the store read, the queue and the output
// register after voxel e+W*H (or the flush standing for it) is accepted.
// in_tready is low for one cycle after every configuration write.
// Reset is synchronous; the voxel store needs no clearing and is ready at once.
`timescale 1ns / 1ps
`default_nettype none

module label_surface_voxels #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [lsv_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire [15:0]                  cfg_wdata,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire [lsv_pkg::DATA_W-1:0]   in_tdata,   // voxel_value
  input  wire                         in_tuser,   // flush
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [lsv_pkg::DATA_W-1:0]  out_tdata,  // out_value
  output logic                        out_tlast
);

  lsv_pkg::cfg_t      cfg_r;
  logic               hold_r;
  logic               restart;
  lsv_pkg::push_t     push;
  lsv_pkg::q_status_t q_stat;

  assign restart = cfg_we &&
                   (cfg_addr inside {lsv_pkg::CFG_FOREGROUND, lsv_pkg::CFG_SURFACE,
                                     lsv_pkg::CFG_WIDTH, lsv_pkg::CFG_HEIGHT,
                                     lsv_pkg::CFG_DEPTH});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg      <= 16'd1;
      cfg_r.surface <= 16'd1;
      cfg_r.width   <= 9'd256;
      cfg_r.height  <= 9'd256;
      cfg_r.depth   <= 16'd1;
      hold_r        <= 1'b1;
    end else begin
      hold_r <= cfg_we;
      if (cfg_we) begin
        case (lsv_pkg::cfg_idx_t'(cfg_addr))
          lsv_pkg::CFG_FOREGROUND: cfg_r.fg      <= cfg_wdata;
          lsv_pkg::CFG_SURFACE:    cfg_r.surface <= cfg_wdata;
          lsv_pkg::CFG_WIDTH:      cfg_r.width   <= cfg_wdata[8:0];
          lsv_pkg::CFG_HEIGHT:     cfg_r.height  <= cfg_wdata[8:0];
          lsv_pkg::CFG_DEPTH:      cfg_r.depth   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  lsv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_hold  (hold_r),
    .restart   (restart),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push)
  );

  lsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .push       (push),
    .q_stat     (q_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/lsv_checker.sv =====
// ----------------------------------------------------------------------------
// lsv_checker
// Port-level checks for the surface labelling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lsv_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        cfg_we,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire        out_tlast
);

  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "word dropped")
  `ASSERT_CLKD(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "stalled word changed")
  `ASSERT_CLKD(a_cfg_stall, clk, rst_n, cfg_we |=> !in_tready, "input taken right after a write")
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid && !in_tready, "active after reset")

endmodule

bind label_surface_voxels lsv_checker u_lsv_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the face-connected surface labelling block.
//
// Small volumes with random labels are streamed through the block with random
// gaps on both channels. A behavioral predictor keeps its own voxel store,
// raster position and register copy. It queues the expected label and
// end-of-volume flag for every accepted input word that yields a result. Each
// accepted output word is checked against the oldest queued expectation. The
// run also covers register extremes, out-of-range sizes, early, idle and extra
// flushes, and voxels that arrive during the drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [15:0] label;
    logic        last;
  } surf_word_t;

  class surface_scoreboard;
    bit [15:0]  store [131072];
    longint     px, py, pz, done_cnt;
    bit [15:0]  fg, sv, dep;
    bit [8:0]   wid, hgt;
    surf_word_t pending [$];
    int         errors;

    function new();
      fg = 16'd1; sv = 16'd1; wid = 9'd256; hgt = 9'd256; dep = 16'd1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      px = 0; py = 0; pz = 0; done_cnt = 0;
    endfunction

    function longint eff_w();
      return (wid == 0) ? 1 : (wid > 256) ? 256 : wid;
    endfunction

    function longint eff_h();
      return (hgt == 0) ? 1 : (hgt > 256) ? 256 : hgt;
    endfunction

    function longint eff_d();
      return (dep == 0) ? 1 : dep;
    endfunction

    function void write_reg(lsv_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        lsv_pkg::CFG_FOREGROUND: fg = val;
        lsv_pkg::CFG_SURFACE:    sv = val;
        lsv_pkg::CFG_WIDTH:      wid = val[8:0];
        lsv_pkg::CFG_HEIGHT:     hgt = val[8:0];
        lsv_pkg::CFG_DEPTH:      dep = val;
        default:                 return;
      endcase
      restart();
    endfunction

    function bit [15:0] voxel_at(longint idx, longint cur, bit [15:0] inc, bit have);
      if (have && idx == cur) return inc;
      return store[idx % 131072];
    endfunction

    function bit [15:0] surface_label(longint e, longint cur, bit [15:0] inc, bit have);
      longint w, h, d, pl, x, y, z;
      bit     edge_hit;
      w = eff_w(); h = eff_h(); d = eff_d(); pl = w * h;
      x = e % w; y = (e / w) % h; z = e / pl;
      edge_hit = 1'b0;
      if (voxel_at(e, cur, inc, have) != fg) return 16'd0;
      if (x >= 1 && voxel_at(e - 1, cur, inc, have) != fg) edge_hit = 1'b1;
      if (x + 1 < w && voxel_at(e + 1, cur, inc, have) != fg) edge_hit = 1'b1;
      if (y >= 1 && voxel_at(e - w, cur, inc, have) != fg) edge_hit = 1'b1;
      if (y + 1 < h && voxel_at(e + w, cur, inc, have) != fg) edge_hit = 1'b1;
      if (z >= 1 && voxel_at(e - pl, cur, inc, have) != fg) edge_hit = 1'b1;
      if (z + 1 < d && voxel_at(e + pl, cur, inc, have) != fg) edge_hit = 1'b1;
      return edge_hit ? sv : 16'd0;
    endfunction

    function void note_input(logic [15:0] v, logic flush);
      longint     w, h, d, pl, total, e, n;
      bit         complete, emit;
      surf_word_t r;
      w = eff_w(); h = eff_h(); d = eff_d();
      pl = w * h; total = pl * d; e = done_cnt;
      complete = (pz >= d);
      emit = 1'b0;
      r.label = 16'd0;
      if (!flush && !complete) begin
        n = (pz * h + py) * w + px;
        if (e + pl == n) begin
          r.label = surface_label(e, n, v, 1'b1);
          emit = 1'b1;
        end
        store[n % 131072] = v;
        px++;
        if (px >= w) begin
          px = 0; py++;
          if (py >= h) begin
            py = 0; pz++;
          end
        end
      end else if (complete && e < total) begin
        r.label = surface_label(e, 0, 16'd0, 1'b0);
        emit = 1'b1;
      end
      if (emit) begin
        r.last = (e + 1 == total);
        pending = {pending, r};
        done_cnt = e + 1;
        if (r.last) restart();
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(logic [15:0] label, logic last);
      surf_word_t x;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output word label=%h last=%b", label, last));
        return;
      end
      x = pending.pop_front();
      if (label !== x.label)
        report($sformatf("label got %h expected %h", label, x.label));
      if (last !== x.last)
        report($sformatf("last got %b expected %b", last, x.last));
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  lsv_pkg::cfg_idx_t cfg_addr = lsv_pkg::CFG_FOREGROUND;
  logic [15:0]       cfg_wdata = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [15:0]       in_tdata = 0;
  logic              in_tuser = 0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [15:0]       out_tdata;
  logic              out_tlast;

  surface_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int sent = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  label_surface_voxels uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("label_surface_voxels test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        @(negedge clk) out_tready = 0;
        repeat (250) @(negedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        @(negedge clk) out_tready = 0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready = 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task send_word(logic [15:0] v, logic flush);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk) in_tvalid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1;
    in_tdata = v;
    in_tuser = flush;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task wait_drain();
    @(negedge clk) in_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_regs(logic [15:0] fg, logic [15:0] sv, logic [15:0] w, logic [15:0] h,
                  logic [15:0] d);
    lsv_pkg::cfg_idx_t ids [5];
    logic [15:0]       vals [5];
    ids = '{lsv_pkg::CFG_FOREGROUND, lsv_pkg::CFG_SURFACE, lsv_pkg::CFG_WIDTH,
            lsv_pkg::CFG_HEIGHT, lsv_pkg::CFG_DEPTH};
    vals = '{fg, sv, w, h, d};
    wait_drain();
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we = 1;
      cfg_addr = ids[i];
      cfg_wdata = vals[i];
      sb.write_reg(ids[i], vals[i]);
    end
    @(negedge clk) cfg_we = 0;
  endtask

  function logic [15:0] pick_voxel(logic [15:0] fg);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return fg;
    if (r < 85) return fg ^ (16'd1 << $urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // Streams a whole volume, then drains it with flushes; voxels and early
  // flushes are mixed in as the arguments ask.
  task run_volume(logic [15:0] fg, logic [15:0] sv, int w, int h, int d, bit noise);
    longint ew, eh, ed, total, pl;
    write_regs(fg, sv, 16'(w), 16'(h), 16'(d));
    ew = sb.eff_w(); eh = sb.eff_h(); ed = sb.eff_d();
    pl = ew * eh; total = pl * ed;
    for (longint i = 0; i < total; i++) begin
      if (noise && i > 0 && $urandom_range(0, 19) == 0) send_word(16'($urandom), 1'b1);
      send_word(pick_voxel(fg), 1'b0);
    end
    for (longint i = 0; i < pl; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_word(pick_voxel(fg), 1'b0);
      else send_word(16'($urandom), 1'b1);
    end
    if (noise) repeat ($urandom_range(0, 2)) send_word(16'($urandom), 1'b1);
  endtask

  initial begin
    int    w, h, d, vol;
    logic [15:0] fg;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // Directed part: flush with nothing pending, label extremes, early flush,
    // a voxel during the drain, and the deepest volume left unfinished.
    calm = 1;
    send_word(16'hFFFF, 1'b1);
    write_regs(16'hFFFF, 16'hFFFF, 16'd2, 16'd2, 16'd2);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b1);
    write_regs(16'h0000, 16'h0000, 16'd1, 16'd1, 16'hFFFF);
    repeat (5) send_word(16'h0000, 1'b0);
    run_volume(16'h0000, 16'hA5A5, 0, 0, 0, 1'b0);

    // Register extremes and out-of-range sizes.
    calm = 0;
    run_volume(16'h8000, 16'h7FFF, 300, 1, 0, 1'b1);
    run_volume(16'h0007, 16'hFFFF, 1, 511, 1, 1'b0);

    // Random volumes, mostly small; one with a long output stall and every
    // seventh one, from the sixth on, with no idling at all.
    vol = 0;
    while (sent < 1800 || vol < 6) begin
      fg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      d = $urandom_range(1, 4);
      calm = (vol % 7 == 5);
      if (vol == 3) begin
        w = 4; h = 4; d = 3;
        hold_req = 1;
      end
      run_volume(fg, 16'($urandom), w, h, d, 1'b1);
      vol++;
    end
    calm = 0;

    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));
    if (sb.errors == 0)
      $display("label_surface_voxels test passed");
    else
      $display("label_surface_voxels test failed");
    $finish;
  end

endmodule
